// ----- sv/srgbmip_pkg.sv -----
// ============================================================================
// srgbmip_pkg: shared types, constants and tables of the sRGB mip downsampler
// Holds the channel payload types, the work item carried from front to back,
// the back pipeline stage record and the two sRGB conversion tables. The
// tables are evaluated at elaboration from the sRGB transfer curve.
// ============================================================================
package srgbmip_pkg;

   // Linear-light resolution: 2^LIN_BITS - 1 stands for 1.0
   localparam int LIN_BITS      = 16;
   localparam int PAIR_BITS     = LIN_BITS + 1;
   localparam int SUM_BITS      = LIN_BITS + 2;
   localparam int HEIGHT_LIMIT  = 4096;
   localparam int ROW_BITS      = $clog2(HEIGHT_LIMIT);
   localparam int SIZE_BITS     = 13;
   localparam int CSR_IDX_BITS  = 2;
   localparam int SEARCH_STEPS  = 8;
   localparam int QUEUE_DEPTH   = 4;

   // Register map
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_SRGB_MODE     = 2'd2
   } csr_index_type;

   // Channel payloads
   typedef struct packed {
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
      logic       last_pixel;
   } rsp_type;

   // One converted source pixel (color index 0 red, 1 green, 2 blue)
   typedef struct packed {
      logic [2:0][LIN_BITS-1:0] color;
      logic [7:0]               alpha;
   } pixel_type;

   // Sum of a horizontal pixel pair; also the line buffer entry
   typedef struct packed {
      logic [2:0][PAIR_BITS-1:0] color;
      logic [8:0]                alpha;
   } pair_type;

   typedef enum logic {
      OP_STORE = 1'b0,
      OP_EMIT  = 1'b1
   } op_kind_type;

   // Work item handed from the front to the back
   typedef struct packed {
      op_kind_type kind;
      logic        dup;
      logic        srgb;
      logic        last;
      pair_type    pair;
   } op_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Back pipeline stage record
   typedef struct packed {
      logic                     valid;
      logic                     srgb;
      logic                     last;
      logic [7:0]               alpha;
      logic [2:0][7:0]          plain;
      logic [2:0][LIN_BITS-1:0] idx;
      logic [2:0][7:0]          code;
   } stage_type;

   typedef logic [255:0][LIN_BITS-1:0] lin_table_type;

   // Fixed-point constants of the transfer curve (denominator 510 throughout)
   localparam longint unsigned LIN_MAX      = (64'd1 << LIN_BITS) - 64'd1;
   localparam longint unsigned Q_ONE        = 64'd1 << 31;
   localparam longint unsigned DEC_OFS      = 64'd55 * 64'd510;
   localparam longint unsigned DEC_DEN      = 64'd1055 * 64'd510;
   localparam longint unsigned SEG_LIMIT    = 64'd4045 * 64'd510;
   localparam longint unsigned LIN_SEG_DEN  = 64'd1292 * 64'd510;
   localparam longint unsigned LIN_SEG_HALF = 64'd1292 * 64'd255;

   // Line buffer address width for a given maximum source width
   function automatic int line_addr_bits(input int max_width);
      int depth;
      depth = (max_width + 1) / 2;
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // Q1.31 product, truncated
   function automatic longint unsigned qmul(input longint unsigned a,
                                            input longint unsigned b);
      return (a * b) >> 31;
   endfunction

   // Largest Q1.31 value whose fifth power does not exceed s
   function automatic longint unsigned root5(input longint unsigned s);
      longint unsigned lo, hi, mid, p;
      lo = 64'd0;
      hi = Q_ONE;
      while (lo < hi) begin
         mid = (lo + hi + 64'd1) >> 1;
         p = qmul(qmul(qmul(qmul(mid, mid), mid), mid), mid);
         if (p <= s) lo = mid;
         else hi = mid - 64'd1;
      end
      return lo;
   endfunction

   // ((n/510 + 0.055) / 1.055)^2.4 in Q1.31
   function automatic longint unsigned decode_power(input longint unsigned n);
      longint unsigned t, s;
      t = ((64'd1000 * n + DEC_OFS) << 31) / DEC_DEN;
      s = qmul(t, t);
      return qmul(s, root5(s));
   endfunction

   function automatic logic on_segment(input longint unsigned n);
      return (n * 64'd100000) <= SEG_LIMIT;
   endfunction

   // sRGB code to linear value, rounded
   function automatic longint unsigned lin_entry(input int c);
      longint unsigned n;
      n = 64'(2 * c);
      if (on_segment(n)) return (LIN_MAX * 64'd100 * n + LIN_SEG_HALF) / LIN_SEG_DEN;
      else return (LIN_MAX * decode_power(n) + (Q_ONE >> 1)) >> 31;
   endfunction

   // Smallest linear value that maps to code k (midpoint between k-1 and k)
   function automatic longint unsigned threshold_entry(input int k);
      longint unsigned n;
      n = 64'(2 * k - 1);
      if (on_segment(n)) return (LIN_MAX * 64'd100 * n + LIN_SEG_DEN - 64'd1) / LIN_SEG_DEN;
      else return (LIN_MAX * decode_power(n) + Q_ONE - 64'd1) >> 31;
   endfunction

   function automatic lin_table_type build_lin_table();
      lin_table_type t;
      for (int c = 0; c < 256; c++) t[c] = LIN_BITS'(lin_entry(c));
      return t;
   endfunction

   function automatic lin_table_type build_threshold_table();
      lin_table_type t;
      t[0] = '0;
      for (int k = 1; k < 256; k++) t[k] = LIN_BITS'(threshold_entry(k));
      return t;
   endfunction

   localparam lin_table_type LIN_TABLE       = build_lin_table();
   localparam lin_table_type THRESHOLD_TABLE = build_threshold_table();

endpackage

// ----- sv/srgbmip_front.sv -----
// ============================================================================
// srgbmip_front: pixel intake, position tracking and pair forming
// Holds the size and mode registers, walks the source raster, converts each
// pixel to linear light, forms horizontal pair sums and issues store or emit
// work items to the queue. Pixels that add nothing are consumed here.
// ============================================================================
module srgbmip_front #(
   parameter int MAX_WIDTH = 4096,
   localparam int ADDR_BITS = srgbmip_pkg::line_addr_bits(MAX_WIDTH)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  srgbmip_pkg::req_type               req_pixel,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [srgbmip_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [srgbmip_pkg::SIZE_BITS-1:0]  csr_data,
   input  srgbmip_pkg::queue_status_type      q_status,
   output logic                               push,
   output srgbmip_pkg::op_type                push_op,
   output logic [ADDR_BITS-1:0]               push_addr
);

   localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int SIZE_BITS  = srgbmip_pkg::SIZE_BITS;
   localparam int ROW_BITS   = srgbmip_pkg::ROW_BITS;
   localparam int LIN_BITS   = srgbmip_pkg::LIN_BITS;
   localparam int PAIR_BITS  = srgbmip_pkg::PAIR_BITS;
   localparam int CMP_BITS   = (WIDTH_BITS > SIZE_BITS) ? WIDTH_BITS : SIZE_BITS;

   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [SIZE_BITS-1:0]   height_ff, height_in;
   logic                   srgb_ff, srgb_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   srgbmip_pkg::pixel_type hold_ff, hold_in;

   logic                   accept, csr_write, restart;
   logic                   one_wide, one_tall, col_last, row_last;
   logic                   have_pair, emit, store;
   logic [CMP_BITS-1:0]    csr_wide;
   logic [ADDR_BITS-1:0]   last_x;
   logic [ROW_BITS-1:0]    last_y;
   logic [2:0][7:0]        src;
   srgbmip_pkg::pixel_type pix;
   srgbmip_pkg::pair_type  pair;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write && (csr_index == srgbmip_pkg::CSR_SOURCE_WIDTH  ||
                                    csr_index == srgbmip_pkg::CSR_SOURCE_HEIGHT ||
                                    csr_index == srgbmip_pkg::CSR_SRGB_MODE);
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // Register writes, sizes clamped to the supported range
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      srgb_in   = srgb_ff;
      csr_wide  = CMP_BITS'(csr_data);
      if (csr_write) begin
         case (csr_index)
            srgbmip_pkg::CSR_SOURCE_WIDTH: begin
               if (csr_wide == '0) width_in = WIDTH_BITS'(1);
               else if (csr_wide > CMP_BITS'(MAX_WIDTH)) width_in = WIDTH_BITS'(MAX_WIDTH);
               else width_in = WIDTH_BITS'(csr_wide);
            end
            srgbmip_pkg::CSR_SOURCE_HEIGHT: begin
               if (csr_data == '0) height_in = SIZE_BITS'(1);
               else if (csr_data > SIZE_BITS'(srgbmip_pkg::HEIGHT_LIMIT))
                  height_in = SIZE_BITS'(srgbmip_pkg::HEIGHT_LIMIT);
               else height_in = csr_data;
            end
            srgbmip_pkg::CSR_SRGB_MODE: srgb_in = csr_data[0];
            default: ;
         endcase
      end
   end

   // Raster position and destination corner
   assign one_wide = (width_ff == WIDTH_BITS'(1));
   assign one_tall = (height_ff == SIZE_BITS'(1));
   assign col_last = (WIDTH_BITS'(col_ff) == width_ff - WIDTH_BITS'(1));
   assign row_last = (SIZE_BITS'(row_ff) == height_ff - SIZE_BITS'(1));
   assign last_x   = (width_ff < WIDTH_BITS'(2)) ? '0 :
                     ADDR_BITS'((width_ff >> 1) - WIDTH_BITS'(1));
   assign last_y   = (height_ff < SIZE_BITS'(2)) ? '0 :
                     ROW_BITS'((height_ff >> 1) - SIZE_BITS'(1));

   // Linearize and form the horizontal pair
   assign src = {req_pixel.src_blue, req_pixel.src_green, req_pixel.src_red};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pix.color[i] = srgb_ff ? srgbmip_pkg::LIN_TABLE[src[i]] : LIN_BITS'(src[i]);
         if (one_wide) pair.color[i] = {pix.color[i], 1'b0};
         else pair.color[i] = PAIR_BITS'(hold_ff.color[i]) + PAIR_BITS'(pix.color[i]);
      end
      pix.alpha = req_pixel.src_alpha;
      if (one_wide) pair.alpha = {pix.alpha, 1'b0};
      else pair.alpha = 9'(hold_ff.alpha) + 9'(pix.alpha);
   end

   // Classify: upper row stores the pair, lower row (or single row) emits
   assign have_pair = one_wide || col_ff[0];
   assign emit      = have_pair && (one_tall || row_ff[0]);
   assign store     = have_pair && !one_tall && !row_ff[0] && !row_last;

   assign push      = accept && (emit || store);
   assign push_addr = ADDR_BITS'(col_ff >> 1);

   always_comb begin
      push_op.kind = emit ? srgbmip_pkg::OP_EMIT : srgbmip_pkg::OP_STORE;
      push_op.dup  = one_tall;
      push_op.srgb = srgb_ff;
      push_op.last = (push_addr == last_x) && ((row_ff >> 1) == last_y);
      push_op.pair = pair;
   end

   // Counter and left pixel update
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      hold_in = hold_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         hold_in = '0;
      end else if (accept) begin
         if (!col_ff[0] && !col_last) hold_in = pix;
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(1);
         height_ff <= SIZE_BITS'(1);
         srgb_ff   <= 1'b1;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         srgb_ff   <= srgb_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
      hold_ff <= hold_in;
   end

endmodule

// ----- sv/srgbmip_queue.sv -----
// ============================================================================
// srgbmip_queue: work item queue between front and back
// A small FIFO of store and emit items with their line buffer address. Full
// and empty come from a registered count.
// ============================================================================
module srgbmip_queue #(
   parameter int MAX_WIDTH = 4096,
   localparam int ADDR_BITS = srgbmip_pkg::line_addr_bits(MAX_WIDTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  srgbmip_pkg::op_type           push_op,
   input  logic [ADDR_BITS-1:0]          push_addr,
   input  logic                          pop,
   output srgbmip_pkg::op_type           head_op,
   output logic [ADDR_BITS-1:0]          head_addr,
   output srgbmip_pkg::queue_status_type q_status
);

   localparam int DEPTH      = srgbmip_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   srgbmip_pkg::op_type   op_ff [DEPTH];
   logic [ADDR_BITS-1:0]  addr_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign head_op        = op_ff[rd_ptr_ff];
   assign head_addr      = addr_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == COUNT_BITS'(DEPTH));

   // Pointer and occupancy bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + COUNT_BITS'(push) - COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]   <= push_op;
         addr_ff[wr_ptr_ff] <= push_addr;
      end
   end

endmodule

// ----- sv/srgbmip_back.sv -----
// ============================================================================
// srgbmip_back: line buffer and averaging pipeline
// Pops work items, keeps upper-row pair sums in the line buffer, adds the
// lower pair on emit, averages, and in sRGB mode maps linear averages back to
// sRGB codes with a bitwise threshold search, one code bit per stage.
// ============================================================================
module srgbmip_back #(
   parameter int MAX_WIDTH = 4096,
   localparam int ADDR_BITS = srgbmip_pkg::line_addr_bits(MAX_WIDTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  srgbmip_pkg::op_type           head_op,
   input  logic [ADDR_BITS-1:0]          head_addr,
   input  srgbmip_pkg::queue_status_type q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output srgbmip_pkg::rsp_type          rsp_pixel
);

   localparam int DEPTH    = (MAX_WIDTH + 1) / 2;
   localparam int STEPS    = srgbmip_pkg::SEARCH_STEPS;
   localparam int LIN_BITS = srgbmip_pkg::LIN_BITS;
   localparam int SUM_BITS = srgbmip_pkg::SUM_BITS;

   srgbmip_pkg::pair_type  line_mem [DEPTH];
   srgbmip_pkg::pair_type  upper_ff;
   srgbmip_pkg::op_type    op1_ff;
   logic                   valid1_ff, valid1_in;
   srgbmip_pkg::stage_type stage_ff [STEPS + 1];
   srgbmip_pkg::stage_type stage_in [STEPS + 1];
   logic                   advance;

   // Whole pipeline moves together unless the result register is held
   assign advance   = !(stage_ff[STEPS].valid && rsp_stall);
   assign pop       = advance && !q_status.empty;
   assign valid1_in = pop && (head_op.kind == srgbmip_pkg::OP_EMIT);

   // Line buffer: stores write, every pop reads; store items end here
   always_ff @(posedge clock) begin
      if (pop) begin
         if (head_op.kind == srgbmip_pkg::OP_STORE) line_mem[head_addr] <= head_op.pair;
         upper_ff <= line_mem[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid1_ff <= 1'b0;
      else if (advance) valid1_ff <= valid1_in;
      if (advance) op1_ff <= head_op;
   end

   // Window sum, plain averages, then one sRGB code bit per stage
   always_comb begin
      srgbmip_pkg::pair_type upper;
      logic [SUM_BITS-1:0]   sum;
      logic [9:0]            alpha_sum;
      logic [7:0]            trial;

      upper = op1_ff.dup ? op1_ff.pair : upper_ff;
      stage_in[0].valid = valid1_ff;
      stage_in[0].srgb  = op1_ff.srgb;
      stage_in[0].last  = op1_ff.last;
      for (int i = 0; i < 3; i++) begin
         sum = SUM_BITS'(upper.color[i]) + SUM_BITS'(op1_ff.pair.color[i]);
         stage_in[0].plain[i] = 8'((sum + SUM_BITS'(2)) >> 2);
         stage_in[0].idx[i]   = LIN_BITS'(sum >> 2);
         stage_in[0].code[i]  = '0;
      end
      alpha_sum = 10'(upper.alpha) + 10'(op1_ff.pair.alpha);
      stage_in[0].alpha = 8'((alpha_sum + 10'd2) >> 2);

      for (int j = 1; j <= STEPS; j++) begin
         stage_in[j] = stage_ff[j-1];
         for (int i = 0; i < 3; i++) begin
            trial = stage_ff[j-1].code[i] | 8'(1 << (STEPS - j));
            if (srgbmip_pkg::THRESHOLD_TABLE[trial] <= stage_ff[j-1].idx[i])
               stage_in[j].code[i] = trial;
         end
      end

      // Plain mode takes the rounded average instead of the searched code
      for (int i = 0; i < 3; i++) begin
         if (!stage_ff[STEPS-1].srgb) stage_in[STEPS].code[i] = stage_ff[STEPS-1].plain[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= STEPS; j++) begin
         if (reset) stage_ff[j].valid <= 1'b0;
         else if (advance) stage_ff[j] <= stage_in[j];
      end
   end

   // Result register is the last stage
   assign rsp_valid            = stage_ff[STEPS].valid;
   assign rsp_pixel.dst_red    = stage_ff[STEPS].code[0];
   assign rsp_pixel.dst_green  = stage_ff[STEPS].code[1];
   assign rsp_pixel.dst_blue   = stage_ff[STEPS].code[2];
   assign rsp_pixel.dst_alpha  = stage_ff[STEPS].alpha;
   assign rsp_pixel.last_pixel = stage_ff[STEPS].last;

endmodule

// ----- sv/srgb_box_mip_downsample.sv -----
// ============================================================================
// srgb_box_mip_downsample: 2x2 box filter mip level reduction for RGBA8
// Source pixels go in on the req channel in raster order; one destination
// pixel comes out on the rsp channel per complete 2x2 window.
// ============================================================================
// Usage:
//   Write source_width, source_height and srgb_mode on the csr channel while
//   the block is idle; any such write restarts the level at its top-left.
//   Stream source pixels on req (valid/stall), one item per cycle. Items that
//   close a 2x2 window produce one rsp item; last_pixel marks the final one.
//   Odd last row/column pixels are consumed without a result.
// Path: the item that closes a window passes the queue, the line buffer read,
//   the window sum, then 8 threshold search stages, one sRGB code bit each.
// Throughput: one item per cycle while rsp is not held; every pop reads the line
//   buffer, and a store item also writes it in the same cycle.
// Reset: counters and queue clear, width and height become 1, sRGB mode on.
//   The line buffer is not cleared; an emit only uses an entry a store wrote first.
// Stall: a held rsp freezes the back pipeline; the 4-entry work queue fills
//   and then req_stall rises until results drain.
// ============================================================================
module srgb_box_mip_downsample #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  srgbmip_pkg::req_type                 req_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output srgbmip_pkg::rsp_type                 rsp_pixel,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [srgbmip_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [srgbmip_pkg::SIZE_BITS-1:0]    csr_data
);

   localparam int ADDR_BITS = srgbmip_pkg::line_addr_bits(MAX_WIDTH);

   logic                          push, pop;
   srgbmip_pkg::op_type           push_op, head_op;
   logic [ADDR_BITS-1:0]          push_addr, head_addr;
   srgbmip_pkg::queue_status_type q_status;

   // Front: registers, raster walk, pair forming
   srgbmip_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pixel (req_pixel),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .push      (push),
      .push_op   (push_op),
      .push_addr (push_addr)
   );

   // Work queue
   srgbmip_queue #(.MAX_WIDTH(MAX_WIDTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .push_addr (push_addr),
      .pop       (pop),
      .head_op   (head_op),
      .head_addr (head_addr),
      .q_status  (q_status)
   );

   // Back: line buffer, averaging and sRGB encode
   srgbmip_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_op   (head_op),
      .head_addr (head_addr),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_pixel (rsp_pixel)
   );

   // The front only issues work while the queue has room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("work item pushed into a full queue");

   // The back only takes work that is there
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("work item popped from an empty queue");

   // Reset leaves no queued work and no pending result
   a_reset_empty: assert property (@(posedge clock)
      reset |=> q_status.empty && !rsp_valid)
      else $error("queue or result not cleared by reset");

endmodule

// ----- verif/tb_srgb_box_mip_downsample.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_srgb_box_mip_downsample: self-checking bench for the sRGB mip reducer
// Streams RGBA8 source pixels through the block under several image sizes,
// both color modes and four idle/stall patterns. A built-in predictor keeps
// its own line buffer, counters and sRGB tables and checks every mip pixel,
// field by field, in order.
// ============================================================================
module tb_srgb_box_mip_downsample;

   localparam int          WIDTH_CAP    = 4096;
   localparam int          HEIGHT_CAP   = 4096;
   localparam int          PAIR_SLOTS   = WIDTH_CAP / 2;
   localparam int          DRAIN_CYCLES = 16;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          RANDOM_ITEMS = 1950;
   localparam longint unsigned LIN_FULL = 64'd65535;
   localparam longint unsigned Q31_ONE  = 64'd1 << 31;
   // index past the register map; a write there must change nothing
   localparam logic [srgbmip_pkg::CSR_IDX_BITS-1:0] CSR_UNMAPPED = 2'd3;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   srgbmip_pkg::req_type                 req_pixel = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   srgbmip_pkg::rsp_type                 rsp_pixel;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [srgbmip_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [srgbmip_pkg::SIZE_BITS-1:0]    csr_data = '0;

   srgb_box_mip_downsample dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_pixel (rsp_pixel),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: sRGB tables, registers, line buffer and position
   // ---------------------------------------------------------------------
   int unsigned    to_linear [256];
   int unsigned    code_floor [256];
   logic [12:0]    cfg_width = 13'd1;
   logic [12:0]    cfg_height = 13'd1;
   logic           cfg_srgb = 1'b1;
   int unsigned    upper_pairs [PAIR_SLOTS][4];
   int unsigned    left_hold [4];
   int unsigned    src_col = 0;
   int unsigned    src_row = 0;

   srgbmip_pkg::req_type pixel_backlog [$];
   srgbmip_pkg::rsp_type mip_expected [$];
   int             queued_count = 0;
   int             accepted_count = 0;
   int             results_checked = 0;
   int             error_count = 0;
   int             cycle_count = 0;
   int             sender_idle_pct = 0;
   int             receiver_stall_pct = 0;
   bit             req_taken = 1'b0;

   function automatic longint unsigned q31_mul(input longint unsigned a,
                                               input longint unsigned b);
      return (a * b) >> 31;
   endfunction

   // Largest Q1.31 value whose fifth power stays at or below s
   function automatic longint unsigned fifth_root(input longint unsigned s);
      longint unsigned lo, hi, mid, p;
      lo = 0;
      hi = Q31_ONE;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         p = q31_mul(q31_mul(q31_mul(q31_mul(mid, mid), mid), mid), mid);
         if (p <= s) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // ((n/d + 0.055) / 1.055)^2.4 in Q1.31, as t^2 * t^(2/5)
   function automatic longint unsigned curve_power(input longint unsigned n,
                                                   input longint unsigned d);
      longint unsigned t, s;
      t = ((64'd1000 * n + 64'd55 * d) << 31) / (64'd1055 * d);
      s = q31_mul(t, t);
      return q31_mul(s, fifth_root(s));
   endfunction

   function automatic bit near_black(input longint unsigned n, input longint unsigned d);
      return n * 64'd100000 <= 64'd4045 * d;
   endfunction

   function automatic logic [7:0] to_code(input int unsigned level);
      logic [7:0] code;
      code = 8'd0;
      for (int k = 1; k < 256; k++)
         if (code_floor[k] <= level) code = 8'(k);
      return code;
   endfunction

   function automatic int unsigned clamp_size(input logic [12:0] size, input int cap);
      if (size == 0) return 1;
      if (size > cap) return cap;
      return size;
   endfunction

   function automatic void restart_level();
      src_col = 0;
      src_row = 0;
      for (int i = 0; i < 4; i++) left_hold[i] = 0;
   endfunction

   // Advance the predictor by one source pixel; emits tells if a mip pixel results
   task automatic mip_step(input srgbmip_pkg::req_type px, output bit emits,
                           output srgbmip_pkg::rsp_type res);
      int unsigned w, h, c, r, x, ow, oh, y;
      int unsigned lin [4];
      int unsigned pair [4];
      int unsigned sum [4];
      bit          have_pair;
      w = clamp_size(cfg_width, WIDTH_CAP);
      h = clamp_size(cfg_height, HEIGHT_CAP);
      c = (src_col >= w) ? 0 : src_col;
      r = (src_row >= h) ? 0 : src_row;
      lin[0] = cfg_srgb ? to_linear[px.src_red] : px.src_red;
      lin[1] = cfg_srgb ? to_linear[px.src_green] : px.src_green;
      lin[2] = cfg_srgb ? to_linear[px.src_blue] : px.src_blue;
      lin[3] = px.src_alpha;
      have_pair = 1'b0;
      emits = 1'b0;
      x = 0;
      res = '0;

      // horizontal pair: one-wide sources use the pixel twice
      if (w == 1) begin
         for (int i = 0; i < 4; i++) pair[i] = 2 * lin[i];
         have_pair = 1'b1;
      end else if (c[0]) begin
         for (int i = 0; i < 4; i++) pair[i] = left_hold[i] + lin[i];
         x = c >> 1;
         have_pair = 1'b1;
      end else if (c + 1 < w) begin
         left_hold = lin;
      end
      if (x >= PAIR_SLOTS) x = PAIR_SLOTS - 1;

      // vertical pair: one-tall sources use the row twice
      if (have_pair) begin
         if (h == 1) begin
            for (int i = 0; i < 4; i++) sum[i] = 2 * pair[i];
            emits = 1'b1;
         end else if (r[0]) begin
            for (int i = 0; i < 4; i++) sum[i] = upper_pairs[x][i] + pair[i];
            emits = 1'b1;
         end else if (r + 1 < h) begin
            upper_pairs[x] = pair;
         end
      end

      if (emits) begin
         ow = (w / 2 != 0) ? w / 2 : 1;
         oh = (h / 2 != 0) ? h / 2 : 1;
         y = (h == 1) ? 0 : (r >> 1);
         res.dst_red    = cfg_srgb ? to_code(sum[0] >> 2) : 8'((sum[0] + 2) >> 2);
         res.dst_green  = cfg_srgb ? to_code(sum[1] >> 2) : 8'((sum[1] + 2) >> 2);
         res.dst_blue   = cfg_srgb ? to_code(sum[2] >> 2) : 8'((sum[2] + 2) >> 2);
         res.dst_alpha  = 8'((sum[3] + 2) >> 2);
         res.last_pixel = (x == ow - 1) && (y == oh - 1);
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      src_col = c;
      src_row = r;
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Source pixel driver: holds a stalled item, otherwise idles at random
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (pixel_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_pixel <= pixel_backlog[0];
            pixel_backlog.delete(0);
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each accepted pixel, check each accepted result
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bit                   emits;
      srgbmip_pkg::rsp_type predicted;
      srgbmip_pkg::rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            accepted_count++;
            mip_step(req_pixel, emits, predicted);
            if (emits) mip_expected.insert(mip_expected.size(), predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (mip_expected.size() == 0) begin
               $error("unexpected mip pixel %h with nothing pending", rsp_pixel);
               error_count++;
            end else begin
               want = mip_expected[0];
               mip_expected.delete(0);
               check_field("dst_red", want.dst_red, rsp_pixel.dst_red);
               check_field("dst_green", want.dst_green, rsp_pixel.dst_green);
               check_field("dst_blue", want.dst_blue, rsp_pixel.dst_blue);
               check_field("dst_alpha", want.dst_alpha, rsp_pixel.dst_alpha);
               check_field("last_pixel", want.last_pixel, rsp_pixel.last_pixel);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d mip pixels still pending",
                  cycle_count, mip_expected.size());
         $display("** srgb_box_mip_downsample: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic csr_write(input logic [srgbmip_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [12:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         srgbmip_pkg::CSR_SOURCE_WIDTH: begin
            cfg_width = value;
            restart_level();
         end
         srgbmip_pkg::CSR_SOURCE_HEIGHT: begin
            cfg_height = value;
            restart_level();
         end
         srgbmip_pkg::CSR_SRGB_MODE: begin
            cfg_srgb = value[0];
            restart_level();
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait for every pixel to be taken and every result to arrive, then let
   // trailing non-emitting items clear the pipeline
   task automatic settle();
      while (accepted_count != queued_count || mip_expected.size() != 0)
         @(negedge clock);
      receiver_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic queue_pixel(input srgbmip_pkg::req_type px);
      pixel_backlog.insert(pixel_backlog.size(), px);
      queued_count++;
   endtask

   function automatic srgbmip_pkg::req_type make_pixel(input logic [7:0] r,
                                                       input logic [7:0] g,
                                                       input logic [7:0] b,
                                                       input logic [7:0] a);
      srgbmip_pkg::req_type px;
      px.src_red   = r;
      px.src_green = g;
      px.src_blue  = b;
      px.src_alpha = a;
      return px;
   endfunction

   // Channel bytes lean toward the extremes now and then
   function automatic logic [7:0] random_byte();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      longint unsigned n;
      int              phase_no;
      int              random_items;
      int              first_reg;
      int              eff_w, eff_h, items;
      logic [12:0]     new_width, new_height;

      // sRGB tables from the transfer curve
      for (longint unsigned c = 0; c < 256; c++) begin
         if (near_black(c, 255))
            to_linear[c] = 32'((2 * LIN_FULL * 100 * c + 1292 * 255) / (2 * 1292 * 255));
         else
            to_linear[c] = 32'((LIN_FULL * curve_power(c, 255) + (Q31_ONE >> 1)) >> 31);
      end
      code_floor[0] = 0;
      for (longint unsigned k = 1; k < 256; k++) begin
         n = 2 * k - 1;
         if (near_black(n, 510))
            code_floor[k] = 32'((LIN_FULL * 100 * n + 1292 * 510 - 1) / (1292 * 510));
         else
            code_floor[k] = 32'((LIN_FULL * curve_power(n, 510) + Q31_ONE - 1) >> 31);
      end

      restart_level();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values: 1x1 source in sRGB mode, every pixel is its own mip
      queue_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
      queue_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      queue_pixel(make_pixel(8'd10, 8'd11, 8'd12, 8'h80));  // around the linear knee
      queue_pixel(make_pixel(8'hAA, 8'h55, 8'h01, 8'hFE));
      queue_pixel(make_pixel(8'h55, 8'hAA, 8'hFE, 8'h01));
      settle();

      // Plain averaging, still 1x1
      csr_write(srgbmip_pkg::CSR_SRGB_MODE, 13'd0);
      queue_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
      queue_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      queue_pixel(make_pixel(8'h80, 8'h7F, 8'h01, 8'hFE));
      settle();

      // One 2x2 window in sRGB with black/white mixes
      csr_write(srgbmip_pkg::CSR_SOURCE_WIDTH, 13'd2);
      csr_write(srgbmip_pkg::CSR_SOURCE_HEIGHT, 13'd2);
      csr_write(srgbmip_pkg::CSR_SRGB_MODE, 13'd1);
      queue_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'hFF));
      queue_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 8'h00));
      queue_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF));
      queue_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFE));
      settle();

      // 3x3 plain: odd last column and row are dropped
      csr_write(srgbmip_pkg::CSR_SOURCE_WIDTH, 13'd3);
      csr_write(srgbmip_pkg::CSR_SOURCE_HEIGHT, 13'd3);
      csr_write(srgbmip_pkg::CSR_SRGB_MODE, 13'd0);
      for (int i = 0; i < 9; i++)
         queue_pixel(make_pixel(8'(i * 29), 8'(255 - i * 31), 8'(i[0] ? 255 : 0),
                                8'(i * 3 + 1)));
      settle();

      // Random phases of sizes, modes and idle patterns
      phase_no = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         settle();
         if ($urandom_range(99) < 8) begin
            // unmapped write: the level carries on where it stood
            csr_write(CSR_UNMAPPED, 13'($urandom));
         end else begin
            case ($urandom_range(19))
               0: begin
                  new_width = 13'd0;
                  new_height = 13'($urandom_range(0, 6));
               end
               1: begin
                  new_width = $urandom_range(1) ? 13'd4096 : 13'($urandom_range(4097, 8191));
                  new_height = 13'($urandom_range(1, 2));
               end
               2: begin
                  new_width = 13'($urandom_range(1, 4));
                  new_height = $urandom_range(1) ? 13'd4096 : 13'($urandom_range(4097, 8191));
               end
               3: begin
                  new_width = 13'($urandom_range(11, 40));
                  new_height = 13'($urandom_range(0, 5));
               end
               default: begin
                  new_width = 13'($urandom_range(1, 10));
                  new_height = 13'($urandom_range(1, 9));
               end
            endcase
            first_reg = $urandom_range(2);
            for (int j = 0; j < 3; j++) begin
               case ((first_reg + j) % 3)
                  0: csr_write(srgbmip_pkg::CSR_SOURCE_WIDTH, new_width);
                  1: csr_write(srgbmip_pkg::CSR_SOURCE_HEIGHT, new_height);
                  default: csr_write(srgbmip_pkg::CSR_SRGB_MODE, 13'($urandom));
               endcase
            end
         end

         eff_w = clamp_size(cfg_width, WIDTH_CAP);
         eff_h = clamp_size(cfg_height, HEIGHT_CAP);
         items = eff_w * eff_h * $urandom_range(1, 2);
         if ($urandom_range(2) == 0) items += $urandom_range(0, eff_w * eff_h - 1);
         if (items > 240) items = $urandom_range(120, 240);

         case (phase_no % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 65;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 65;
            end
            default: begin
               sender_idle_pct = 19;
               receiver_stall_pct = 19;
            end
         endcase

         for (int i = 0; i < items; i++)
            queue_pixel(make_pixel(random_byte(), random_byte(), random_byte(),
                                   random_byte()));
         random_items += items;
         phase_no++;
      end

      settle();
      $display("Streamed %0d source pixels over %0d random phases of varied size and mode;",
               queued_count, phase_no);
      $display("checked %0d mip pixels, %0d mismatches.", results_checked, error_count);
      if (error_count == 0 && mip_expected.size() == 0) begin
         $display("** srgb_box_mip_downsample: PASSED **");
      end else begin
         $display("** srgb_box_mip_downsample: FAILED **");
      end
      $finish;
   end

endmodule
